[sv/run_merge_sorter_macros.svh]
// Assertion macros shared by the sorter RTL.
`ifndef RUN_MERGE_SORTER_MACROS_SVH
`define RUN_MERGE_SORTER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define RMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rms_pkg.sv]
// ----------------------------------------------------------------------------
// rms_pkg
// Sizes and shared types of the run merge sorter.
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // One position of the sorting chain.
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
    } slot_t;

    // Operation applied to every cell of the chain together.
    typedef struct packed {
        logic insert;
        logic drain;
    } chain_ctrl_t;

endpackage

[sv/run_merge_sorter.sv]
// ----------------------------------------------------------------------------
// run_merge_sorter
// Collects a set of signed values and returns them in ascending order.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low;
// value and last travel with it. While a set loads, one request is taken
// every cycle and inserted into a chain of 64 sorting cells, so the chain is
// always in order. Requests beyond 64 in one set are dropped.
// The request with last set ends the set. From the next cycle busy is high
// and the sorted burst leaves the head of the chain, one result per cycle,
// with strobe high on each. last_res marks the final result; overflow is
// high on every result of a set that lost requests. Busy falls in the
// cycle after the final result.
// The receiver cannot stall: each result is present for exactly one cycle.
// Reset empties the chain and clears the count and the overflow flag.
module run_merge_sorter
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rms_pkg::DATA_W-1:0] value,
    input  logic                              last,
    output logic                              strobe,
    output logic signed [rms_pkg::DATA_W-1:0] sorted_value,
    output logic                              last_res,
    output logic                              overflow
);

`include "run_merge_sorter_macros.svh"

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [rms_pkg::CNT_W-1:0]  count_reg;
    logic [rms_pkg::CNT_W-1:0]  count_next;
    logic [rms_pkg::CNT_W-1:0]  remain_reg;
    logic [rms_pkg::CNT_W-1:0]  remain_next;
    logic                       dropped_reg;
    logic                       dropped_next;

    logic                       accept;
    logic                       full;
    rms_pkg::chain_ctrl_t       ctrl;
    rms_pkg::slot_t             head;

    assign busy   = (state_reg == ST_DRAIN);
    assign accept = start && !busy;
    assign full   = (count_reg == rms_pkg::CNT_W'(rms_pkg::MAX_ITEMS));

    assign ctrl.insert = accept && !full;
    assign ctrl.drain  = busy;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        remain_next  = remain_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    dropped_next = dropped_reg || full;
                    if (last)
                    begin
                        state_next  = ST_DRAIN;
                        count_next  = '0;
                        remain_next = full ? count_reg : count_reg + 1'b1;
                    end
                    else if (!full)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                remain_next = remain_reg - 1'b1;
                if (remain_reg == rms_pkg::CNT_W'(1))
                begin
                    state_next   = ST_LOAD;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            remain_reg  <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            dropped_reg <= dropped_next;
        end
    end

    rms_chain u_chain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .x     (value),
        .head  (head)
    );

    assign strobe       = busy;
    assign sorted_value = head.value;
    assign last_res     = busy && (remain_reg == rms_pkg::CNT_W'(1));
    assign overflow     = busy && dropped_reg;

    `RMS_ASSERT_NOW(a_head_valid, strobe, head.valid, "result taken from an empty cell")
    `RMS_ASSERT_NEXT(a_burst_ends, strobe && last_res, !busy && (count_reg == '0), "burst did not end cleanly")
    `RMS_ASSERT_NEXT(a_no_early_result, accept && !last, !strobe, "result without a final request")
    `RMS_ASSERT_NOW(a_remain_nonzero, busy, remain_reg != '0, "drain with nothing left")
    `RMS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= rms_pkg::CNT_W'(rms_pkg::MAX_ITEMS), "count beyond capacity")

endmodule

[sv/rms_cell.sv]
// ----------------------------------------------------------------------------
// rms_cell
// One position of the insertion chain: holds one value and trades it with
// its neighbors on insert or drain.
// ----------------------------------------------------------------------------
module rms_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rms_pkg::chain_ctrl_t              ctrl,
    input  logic signed [rms_pkg::DATA_W-1:0] x,
    input  rms_pkg::slot_t                    left_slot,
    input  logic                              left_gt,
    input  rms_pkg::slot_t                    right_slot,
    output rms_pkg::slot_t                    slot,
    output logic                              gt
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [rms_pkg::DATA_W-1:0] value_reg;
    logic signed [rms_pkg::DATA_W-1:0] value_next;

    // An empty cell counts as larger than any value, so the chain stays sorted.
    assign gt = !valid_reg || (value_reg > x);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.drain)
        begin
            valid_next = right_slot.valid;
            value_next = right_slot.value;
        end
        else if (ctrl.insert && gt)
        begin
            // The first larger cell takes the new value; the rest shift right.
            if (left_gt)
            begin
                valid_next = left_slot.valid;
                value_next = left_slot.value;
            end
            else
            begin
                valid_next = 1'b1;
                value_next = x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign slot.valid = valid_reg;
    assign slot.value = value_reg;

endmodule

[sv/rms_chain.sv]
// ----------------------------------------------------------------------------
// rms_chain
// Row of cells kept in ascending order; the head holds the smallest value.
// ----------------------------------------------------------------------------
module rms_chain
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rms_pkg::chain_ctrl_t              ctrl,
    input  logic signed [rms_pkg::DATA_W-1:0] x,
    output rms_pkg::slot_t                    head
);

    rms_pkg::slot_t slots [rms_pkg::MAX_ITEMS];
    logic           gts   [rms_pkg::MAX_ITEMS];

    for (genvar i = 0; i < rms_pkg::MAX_ITEMS; i++)
    begin : g_cell
        rms_pkg::slot_t left_slot;
        logic           left_gt;
        rms_pkg::slot_t right_slot;

        if (i == 0)
        begin : g_first
            assign left_slot = '0;
            assign left_gt   = 1'b0;
        end
        else
        begin : g_mid
            assign left_slot = slots[i-1];
            assign left_gt   = gts[i-1];
        end

        if (i == rms_pkg::MAX_ITEMS - 1)
        begin : g_end
            assign right_slot = '0;
        end
        else
        begin : g_inner
            assign right_slot = slots[i+1];
        end

        rms_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .x          (x),
            .left_slot  (left_slot),
            .left_gt    (left_gt),
            .right_slot (right_slot),
            .slot       (slots[i]),
            .gt         (gts[i])
        );
    end

    assign head = slots[0];

endmodule
